// ----- src/utf8_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8_pkg;

  // Value emitted in place of a broken multi-byte sequence
  localparam logic [31:0] SUBST_CODE = 32'h0000_005E;

  // Depth of the result queue; log2 of it sizes the pointers
  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = 2;
  localparam int RES_CNT_W   = 3;

  // One decoded result word
  typedef struct packed {
    logic [31:0] code_point;
    logic        substituted;
    logic        last_of_run;
  } result_t;

endpackage

// ----- src/utf8_stream_decoder.sv -----
// Lenient UTF-8 decoder: one byte in, zero to two code points out.
`timescale 1ns / 1ps

// The decoder takes one byte per clock while in_tready is high and decodes it
// in the cycle it is accepted, writing its results into a four-word result
// queue. A byte is accepted whenever that queue holds at most two words, so
// the sustained rate is one byte per cycle while the output keeps pace. A byte
// that breaks an open sequence produces the substitute 0x5E, followed by the
// byte's own result unless it is a lead byte, so a stream heavy in broken
// sequences is limited by the output side to one word per cycle. A lead byte
// with no sequence open produces no word; result words are registered.
module utf8_stream_decoder
  import utf8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] code_point
  output logic        out_tuser,  // [0] substituted
  output logic        out_tlast   // last_of_run
);

  // Decoder state
  logic [2:0]  pending_r, pending_nxt;
  logic [31:0] partial_r, partial_nxt;

  // Result queue
  result_t              res_mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RES_CNT_W-1:0] count_r, count_nxt;

  logic        in_acc, out_acc;
  logic        is_cont;
  logic [31:0] cont_value;
  logic [2:0]  cont_pending;
  logic        fresh_emit;
  logic [31:0] fresh_cp;
  logic [2:0]  lead_pending;
  logic [7:0]  lead_mask;
  logic [1:0]  n_push;
  result_t     push0, push1;

  assign in_tready  = (count_r <= RES_CNT_W'(RES_DEPTH - 2));
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_acc    = out_tvalid & out_tready;

  assign out_tdata  = res_mem_r[rd_ptr_r].code_point;
  assign out_tuser  = res_mem_r[rd_ptr_r].substituted;
  assign out_tlast  = res_mem_r[rd_ptr_r].last_of_run;

  assign is_cont      = (in_tdata[7:6] == 2'b10);
  assign cont_value   = {partial_r[25:0], in_tdata[5:0]};
  assign cont_pending = pending_r - 3'd1;

  // Classify a byte seen with no sequence open
  always_comb begin
    fresh_emit   = 1'b0;
    fresh_cp     = {24'd0, in_tdata};
    lead_pending = 3'd0;
    lead_mask    = 8'h00;
    casez (in_tdata)
      8'b0???????: begin
        fresh_emit = 1'b1;
      end
      8'b10??????: begin
        fresh_emit = 1'b1;
        fresh_cp   = {25'd0, in_tdata[6:0]};
      end
      8'b110?????: begin
        lead_pending = 3'd1;
        lead_mask    = 8'h1F;
      end
      8'b1110????: begin
        lead_pending = 3'd2;
        lead_mask    = 8'h0F;
      end
      8'b11110???: begin
        lead_pending = 3'd3;
        lead_mask    = 8'h07;
      end
      8'b111110??: begin
        lead_pending = 3'd4;
        lead_mask    = 8'h03;
      end
      8'b1111110?: begin
        lead_pending = 3'd5;
        lead_mask    = 8'h01;
      end
      8'b11111110: begin
        lead_pending = 3'd6;
      end
      default: begin
        // all ones: keeps no bits, seven continuations follow
        lead_pending = 3'd7;
      end
    endcase
  end

  // Decode the accepted byte into state update and up to two result words
  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    n_push      = 2'd0;
    push0       = '{code_point: fresh_cp, substituted: 1'b0, last_of_run: 1'b1};
    push1       = '{code_point: fresh_cp, substituted: 1'b0, last_of_run: 1'b1};
    if (in_acc) begin
      if ((pending_r != 3'd0) && is_cont) begin
        // shift in six bits, emit when the sequence completes
        pending_nxt = cont_pending;
        if (cont_pending == 3'd0) begin
          partial_nxt      = '0;
          push0.code_point = cont_value;
          n_push           = 2'd1;
        end else begin
          partial_nxt = cont_value;
        end
      end else begin
        if (fresh_emit) begin
          pending_nxt = 3'd0;
          partial_nxt = '0;
        end else begin
          pending_nxt = lead_pending;
          partial_nxt = {24'd0, in_tdata & lead_mask};
        end
        if (pending_r != 3'd0) begin
          // broken sequence: substitute first, then the byte afresh
          push0 = '{code_point: SUBST_CODE, substituted: 1'b1, last_of_run: !fresh_emit};
          n_push = fresh_emit ? 2'd2 : 2'd1;
        end else begin
          n_push = fresh_emit ? 2'd1 : 2'd0;
        end
      end
    end
  end

  assign count_nxt = count_r + RES_CNT_W'(n_push) - RES_CNT_W'(out_acc);

  // Hold decoder state and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
      partial_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
    end else begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
      wr_ptr_r  <= wr_ptr_r + RES_PTR_W'(n_push);
      count_r   <= count_nxt;
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + RES_PTR_W'(1);
      end
    end
  end

  // Write result words into the queue
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      res_mem_r[wr_ptr_r] <= push0;
    end
    if (n_push == 2'd2) begin
      res_mem_r[wr_ptr_r + RES_PTR_W'(1)] <= push1;
    end
  end

endmodule

// ----- tb/utf8_stream_decoder_test.sv -----
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module utf8_stream_decoder_test
  import utf8_pkg::*;
();

  localparam int PHASE_BYTES = 435;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  // Track decoder state and hold the words it should emit, oldest first
  class decode_scoreboard;
    logic [2:0]  seq_left;
    logic [31:0] seq_bits;
    result_t     want_q[$];
    int          errors;

    function new();
      seq_left = '0;
      seq_bits = '0;
      errors   = 0;
    endfunction

    function void queue_word(logic [31:0] cp, logic sub, logic last);
      result_t r;
      r.code_point  = cp;
      r.substituted = sub;
      r.last_of_run = last;
      want_q.push_back(r);
    endfunction

    // Decode a byte with no sequence open; a lead byte opens one and yields nothing
    function bit fresh_value(logic [7:0] b, output logic [31:0] cp);
      int ones;
      cp = '0;
      if (!b[7]) begin
        cp = {24'h0, b};
        return 1'b1;
      end
      if (!b[6]) begin
        cp = {25'h0, b[6:0]};
        return 1'b1;
      end
      ones = 2;
      while (ones < 8 && b[7 - ones]) ones++;
      seq_bits = {24'h0, b} & ((32'h1 << (8 - ones)) - 32'h1);
      seq_left = 3'(ones - 1);
      return 1'b0;
    endfunction

    // Advance the model by one accepted byte and queue the words it causes
    function void note_byte(logic [7:0] b);
      logic [31:0] cp;
      bit          hit;
      if (seq_left != 0) begin
        if (b[7:6] == 2'b10) begin
          seq_bits = {seq_bits[25:0], b[5:0]};
          seq_left = seq_left - 3'd1;
          if (seq_left == 0) begin
            queue_word(seq_bits, 1'b0, 1'b1);
            seq_bits = '0;
          end
        end else begin
          // Broken sequence: substitute, then handle the byte afresh
          seq_left = '0;
          seq_bits = '0;
          hit = fresh_value(b, cp);
          queue_word(SUBST_CODE, 1'b1, !hit);
          if (hit) queue_word(cp, 1'b0, 1'b1);
        end
      end else begin
        hit = fresh_value(b, cp);
        if (hit) queue_word(cp, 1'b0, 1'b1);
      end
    endfunction

    // Compare one received word with the oldest expected one
    function void check_word(logic [31:0] cp, logic sub, logic last);
      result_t want;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected word code_point=%h substituted=%b last=%b",
                 $time, cp, sub, last);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (cp !== want.code_point) begin
        $display("%0t: code_point expected %h actual %h", $time, want.code_point, cp);
        errors++;
      end
      if (sub !== want.substituted) begin
        $display("%0t: substituted expected %b actual %b", $time, want.substituted, sub);
        errors++;
      end
      if (last !== want.last_of_run) begin
        $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run, last);
        errors++;
      end
    endfunction

    function int words_owed();
      return want_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  decode_scoreboard decode_sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  utf8_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Check accepted words and pick the next stall decision
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) decode_sb.check_word(out_tdata, out_tuser, out_tlast);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stop the run when neither side moves a word for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("utf8_stream_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    decode_sb.note_byte(b);
    bytes_sent++;
  endtask

  // Lead byte with k leading ones and random payload bits (k = 1 gives ASCII)
  function automatic logic [7:0] lead_byte(int k);
    logic [7:0] mask;
    if (k == 1) return 8'($urandom_range(127));
    if (k == 8) return 8'hFF;
    mask = (8'h01 << (7 - k)) - 8'h01;
    return ((8'hFF << (8 - k)) & 8'hFF) | (8'($urandom) & mask);
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Send a mix of well-formed, broken and noise bytes until the count is reached
  task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
    int k;
    int cut;
    int pick;
    int stop_at;
    logic [7:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      k = $urandom_range(8, 1);
      if (pick < 70) begin
        send_byte(lead_byte(k));
        for (int i = 1; i < k; i++) send_byte(cont_byte());
      end else if (pick < 85 && k > 1) begin
        // Cut the sequence short and break it with a non-continuation byte
        cut = $urandom_range(k - 2);
        send_byte(lead_byte(k));
        for (int i = 0; i < cut; i++) send_byte(cont_byte());
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        send_byte(b);
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    decode_sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ASCII extremes, stray continuations, valid sequences of two, three and four bytes
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hBF);
    send_byte(8'hC3); send_byte(8'hA9);
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
    send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
    // 0xFF opens seven continuations and overflows the accumulator
    send_byte(8'hFF);
    for (int i = 0; i < 7; i++) send_byte(8'hBF);
    // Broken by ASCII: substitute plus the byte's own word
    send_byte(8'hC3); send_byte(8'h41);
    // Broken by a lead byte: substitute alone marks the end, then finish the new one
    send_byte(8'hE2); send_byte(8'hC3); send_byte(8'hA9);

    // Random: no idling, sender idle, receiver stall, both
    random_phase(0, 0, PHASE_BYTES);
    random_phase(50, 0, PHASE_BYTES);
    random_phase(0, 50, PHASE_BYTES);
    random_phase(34, 34, PHASE_BYTES);

    // Drain outstanding words, then watch for strays
    in_tvalid <= 1'b0;
    while (decode_sb.words_owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (decode_sb.errors == 0) begin
      $display("utf8_stream_decoder regression: pass");
    end else begin
      $display("utf8_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule
